// ----- sv/vpt_pkg.sv -----
// ----------------------------------------------------------------------------
// vpt_pkg: shared types and constants for the video port and line timing core
// Payload structs, request kind and access codes, timing defaults and widths.
// ----------------------------------------------------------------------------
package vpt_pkg;

  // Field and state widths
  localparam int ADDR_W     = 14;
  localparam int CPL_W      = 10;
  localparam int LPF_W      = 9;
  localparam int LCC_W      = 11;
  localparam int PROD_W     = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Memory default
  localparam int VRAM_DEPTH_DEF = 16384;

  // Timing constants
  localparam int ACTIVE_LINES = 192;
  localparam int CPL_DEF      = 228;
  localparam int LPF_DEF      = 262;
  localparam int LPF_PAL_MIN  = 300;
  localparam int HC_SCALE     = 342;
  localparam int VC_PAL_LIM   = 'hF2;
  localparam int VC_PAL_SKIP  = 'h39;
  localparam int VC_NTSC_LIM  = 'hDA;
  localparam int VC_NTSC_SKIP = 6;

  // Divider length: one quotient bit per cycle
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Request kinds
  localparam logic [2:0] KIND_CTRL_WR = 3'd0;
  localparam logic [2:0] KIND_DATA_WR = 3'd1;
  localparam logic [2:0] KIND_DATA_RD = 3'd2;
  localparam logic [2:0] KIND_STAT_RD = 3'd3;
  localparam logic [2:0] KIND_VCOUNT  = 3'd4;
  localparam logic [2:0] KIND_HCOUNT  = 3'd5;
  localparam logic [2:0] KIND_TICK    = 3'd6;

  // Access codes of the second control byte
  localparam logic [1:0] CODE_VRAM_RD = 2'd0;
  localparam logic [1:0] CODE_REG_WR  = 2'd2;
  localparam logic [1:0] CODE_CRAM_WR = 2'd3;

  // Mode register indexes that matter here
  localparam logic [3:0] MREG_0  = 4'd0;
  localparam logic [3:0] MREG_1  = 4'd1;
  localparam logic [3:0] MREG_10 = 4'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CPL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LPF = 2'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] tick_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       irq;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDREQ,
    ST_RDCAP,
    ST_HSTART,
    ST_HDIV,
    ST_TICK,
    ST_FIT,
    ST_MOD,
    ST_RESP
  } state_t;

endpackage

// ----- sv/vpt_ram.sv -----
// ----------------------------------------------------------------------------
// vpt_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module vpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/vpt_div.sv -----
// ----------------------------------------------------------------------------
// vpt_div: iterative restoring divider
// One quotient bit per cycle; gives a quotient and a remainder.
// ----------------------------------------------------------------------------
module vpt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [vpt_pkg::PROD_W-1:0] dividend,
  input  logic [vpt_pkg::CPL_W-1:0]  divisor,
  output logic                      busy,
  output logic                      done,
  output logic [vpt_pkg::PROD_W-1:0] quotient,
  output logic [vpt_pkg::CPL_W-1:0]  remainder
);

  import vpt_pkg::*;

  logic [CPL_W-1:0]     rem_r, rem_nxt;
  logic [PROD_W-1:0]    quo_r, quo_nxt;
  logic [CPL_W-1:0]     div_r, div_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CPL_W:0]       trial;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial    = {rem_r, quo_r[PROD_W-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = CPL_W'(trial - {1'b0, div_r});
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CPL_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- sv/video_chip_port_and_line_timing_core.sv -----
// ----------------------------------------------------------------------------
// video_chip_port_and_line_timing_core: CPU port and scanline timing
// Control/data/status ports over a VRAM, plus line, frame and irq timing.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_valid / in_ready  | in_item_t (kind, data_byte, tick_cycles)
//   out_    | out | out_valid/out_ready  | out_item_t (read_value, irq)
//   cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Paths: status, counter, control first byte and data write go straight to the reply;
//   VRAM prefetch (control code 0, data read) goes through the RAM read; hcount uses the
//   19-step divider; tick crosses one scanline per cycle; config write uses the remainder.
// Reset: a clearing pass writes zero through all VRAM_DEPTH entries, one per cycle,
//   before the first request is taken; config writes are taken meanwhile.
// Stalls: one request in flight; the next is taken while a result waits in the
//   output register, and a finished request holds until that register is free.
// ----------------------------------------------------------------------------
module video_chip_port_and_line_timing_core #(
  parameter int VRAM_DEPTH = vpt_pkg::VRAM_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vpt_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vpt_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vpt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import vpt_pkg::*;

  localparam int VA_W = $clog2(VRAM_DEPTH);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        latch_r, latch_nxt;
  logic [1:0]        code_r, code_nxt;
  logic              pend_r, pend_nxt;
  logic [7:0]        prefetch_r, prefetch_nxt;
  logic              frame_r, frame_nxt;
  logic [LCC_W-1:0]  lcc_r, lcc_nxt;
  logic [LPF_W-1:0]  line_r, line_nxt;
  logic [7:0]        cd_r, cd_nxt;
  logic              ffl_r, ffl_nxt;
  logic              lirq_r, lirq_nxt;
  logic              ie_line_r, ie_line_nxt;
  logic              ie_frame_r, ie_frame_nxt;
  logic [7:0]        reload_r, reload_nxt;
  logic [CPL_W-1:0]  cpl_r, cpl_nxt;
  logic [LPF_W-1:0]  lpf_r, lpf_nxt;
  logic [7:0]        rv_r, rv_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              clearing_r;
  logic [VA_W-1:0]   clr_addr_r;

  logic              in_acc;
  logic              cfg_acc;
  logic [LPF_W-1:0]  line_inc;
  logic [LPF_W-1:0]  vc;
  logic              vram_we;
  logic [VA_W-1:0]   vram_waddr;
  logic [7:0]        vram_wdata;
  logic [7:0]        vram_rdata;
  logic              div_start;
  logic [PROD_W-1:0] div_dividend;
  logic              div_busy;
  logic              div_done;
  logic [PROD_W-1:0] div_quo;
  logic [CPL_W-1:0]  div_rem;

  assign in_ready  = (state_r == ST_IDLE) && !clearing_r && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign line_inc  = line_r + 1'b1;

  // Map the line number to the vertical counter
  always_comb begin
    if (lpf_r >= LPF_W'(LPF_PAL_MIN)) begin
      vc = (line_r <= LPF_W'(VC_PAL_LIM)) ? line_r : line_r - LPF_W'(VC_PAL_SKIP);
    end else begin
      vc = (line_r <= LPF_W'(VC_NTSC_LIM)) ? line_r : line_r - LPF_W'(VC_NTSC_SKIP);
    end
  end

  // VRAM port: clearing pass first, then data writes at the access address
  assign vram_we    = clearing_r ||
                      (in_acc && in_data.kind == KIND_DATA_WR && code_r != CODE_CRAM_WR);
  assign vram_waddr = clearing_r ? clr_addr_r : addr_r[VA_W-1:0];
  assign vram_wdata = clearing_r ? 8'h00 : in_data.data_byte;

  vpt_ram #(
    .WIDTH (8),
    .DEPTH (VRAM_DEPTH)
  ) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (addr_r[VA_W-1:0]),
    .rdata (vram_rdata)
  );

  assign div_start    = (state_r == ST_HSTART) || (state_r == ST_FIT);
  assign div_dividend = (state_r == ST_HSTART) ? prod_r : PROD_W'(lcc_r[CPL_W-1:0]);

  vpt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (cpl_r),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer: next state, register updates and result
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    latch_nxt     = latch_r;
    code_nxt      = code_r;
    pend_nxt      = pend_r;
    prefetch_nxt  = prefetch_r;
    frame_nxt     = frame_r;
    lcc_nxt       = lcc_r;
    line_nxt      = line_r;
    cd_nxt        = cd_r;
    ffl_nxt       = ffl_r;
    lirq_nxt      = lirq_r;
    ie_line_nxt   = ie_line_r;
    ie_frame_nxt  = ie_frame_r;
    reload_nxt    = reload_r;
    cpl_nxt       = cpl_r;
    lpf_nxt       = lpf_r;
    rv_nxt        = rv_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          // Take a timing register, then refit line and cycle position
          if (cfg_index == CFG_CPL) begin
            cpl_nxt   = (cfg_data[CPL_W-1:0] != '0) ? cfg_data[CPL_W-1:0]
                                                    : CPL_W'(CPL_DEF);
            state_nxt = ST_FIT;
          end else if (cfg_index == CFG_LPF) begin
            lpf_nxt   = (cfg_data[LPF_W-1:0] > LPF_W'(ACTIVE_LINES)) ? cfg_data[LPF_W-1:0]
                                                                     : LPF_W'(LPF_DEF);
            state_nxt = ST_FIT;
          end
        end else if (in_acc) begin
          rv_nxt    = 8'h00;
          state_nxt = ST_RESP;
          case (in_data.kind)
            KIND_CTRL_WR: begin
              if (!pend_r) begin
                latch_nxt = in_data.data_byte;
                pend_nxt  = 1'b1;
              end else begin
                pend_nxt = 1'b0;
                code_nxt = in_data.data_byte[7:6];
                addr_nxt = {in_data.data_byte[5:0], latch_r};
                if (in_data.data_byte[7:6] == CODE_VRAM_RD) begin
                  state_nxt = ST_RDREQ;
                end
                if (in_data.data_byte[7:6] == CODE_REG_WR) begin
                  if (in_data.data_byte[3:0] == MREG_0) begin
                    ie_line_nxt = latch_r[4];
                  end
                  if (in_data.data_byte[3:0] == MREG_1) begin
                    ie_frame_nxt = latch_r[5];
                  end
                  if (in_data.data_byte[3:0] == MREG_10) begin
                    reload_nxt = latch_r;
                    cd_nxt     = latch_r;
                  end
                end
              end
            end
            KIND_DATA_WR: begin
              pend_nxt = 1'b0;
              addr_nxt = addr_r + 1'b1;
            end
            KIND_DATA_RD: begin
              pend_nxt  = 1'b0;
              rv_nxt    = prefetch_r;
              state_nxt = ST_RDREQ;
            end
            KIND_STAT_RD: begin
              pend_nxt  = 1'b0;
              rv_nxt    = {frame_r, 7'b0};
              frame_nxt = 1'b0;
              lirq_nxt  = 1'b0;
            end
            KIND_VCOUNT: begin
              rv_nxt = vc[7:0];
            end
            KIND_HCOUNT: begin
              prod_nxt  = PROD_W'(lcc_r[CPL_W-1:0]) * PROD_W'(HC_SCALE);
              state_nxt = ST_HSTART;
            end
            KIND_TICK: begin
              lcc_nxt   = lcc_r + LCC_W'(in_data.tick_cycles);
              state_nxt = ST_TICK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RDREQ: begin
        state_nxt = ST_RDCAP;
      end
      ST_RDCAP: begin
        prefetch_nxt = vram_rdata;
        addr_nxt     = addr_r + 1'b1;
        state_nxt    = ST_RESP;
      end
      ST_HSTART: begin
        state_nxt = ST_HDIV;
      end
      ST_HDIV: begin
        if (div_done) begin
          rv_nxt    = div_quo[7:0];
          state_nxt = ST_RESP;
        end
      end
      ST_TICK: begin
        // Cross one scanline per cycle until the cycle count fits
        if (lcc_r >= LCC_W'(cpl_r)) begin
          lcc_nxt = lcc_r - LCC_W'(cpl_r);
          if (line_r < LPF_W'(ACTIVE_LINES)) begin
            if (ffl_r) begin
              cd_nxt  = reload_r;
              ffl_nxt = 1'b0;
            end else if (cd_r == 8'h00) begin
              cd_nxt   = reload_r;
              lirq_nxt = 1'b1;
            end else begin
              cd_nxt = cd_r - 1'b1;
            end
          end
          if (line_inc == LPF_W'(ACTIVE_LINES)) begin
            frame_nxt = 1'b1;
            cd_nxt    = reload_r;
          end
          if (line_inc >= lpf_r) begin
            line_nxt = '0;
            ffl_nxt  = 1'b1;
          end else begin
            line_nxt = line_inc;
          end
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_FIT: begin
        if (line_r >= lpf_r) begin
          line_nxt = '0;
          ffl_nxt  = 1'b1;
        end
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (div_done) begin
          lcc_nxt   = LCC_W'(div_rem);
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        // Hand over the result once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_value = rv_r;
          out_data_nxt.irq        = (frame_r && ie_frame_r) || (lirq_r && ie_line_r);
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      latch_r     <= '0;
      code_r      <= '0;
      pend_r      <= 1'b0;
      prefetch_r  <= '0;
      frame_r     <= 1'b0;
      lcc_r       <= '0;
      line_r      <= '0;
      cd_r        <= '0;
      ffl_r       <= 1'b1;
      lirq_r      <= 1'b0;
      ie_line_r   <= 1'b0;
      ie_frame_r  <= 1'b0;
      reload_r    <= '0;
      cpl_r       <= CPL_W'(CPL_DEF);
      lpf_r       <= LPF_W'(LPF_DEF);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      latch_r     <= latch_nxt;
      code_r      <= code_nxt;
      pend_r      <= pend_nxt;
      prefetch_r  <= prefetch_nxt;
      frame_r     <= frame_nxt;
      lcc_r       <= lcc_nxt;
      line_r      <= line_nxt;
      cd_r        <= cd_nxt;
      ffl_r       <= ffl_nxt;
      lirq_r      <= lirq_nxt;
      ie_line_r   <= ie_line_nxt;
      ie_frame_r  <= ie_frame_nxt;
      reload_r    <= reload_nxt;
      cpl_r       <= cpl_nxt;
      lpf_r       <= lpf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scratch and payload registers
  always_ff @(posedge clk) begin
    rv_r       <= rv_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sweep zero through VRAM after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == VA_W'(VRAM_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // No request is taken before the clearing pass ends
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_ready)
    else $error("request taken during VRAM clearing pass");

  // Divider runs only for hcount or a timing refit
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == ST_HDIV || state_r == ST_MOD))
    else $error("divider busy outside its states");

  // At rest the line and cycle position lie within the frame and the line
  a_timing_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (line_r < lpf_r && lcc_r < LCC_W'(cpl_r)))
    else $error("timing position out of range while idle");

  // A result is loaded only from the response state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_ready)) |-> $past(state_r == ST_RESP))
    else $error("result appeared without a response step");

endmodule

// ----- sim/video_chip_port_and_line_timing_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_chip_port_and_line_timing_core_test: self-checking bench for the VDP port
// Drives CPU port accesses and time ticks through the request channel. A built-in
// timing and memory model predicts every reply. Replies are checked in order,
// field by field. Several line and frame settings are used, the extremes among them.
// ----------------------------------------------------------------------------
module video_chip_port_and_line_timing_core_test;
  import vpt_pkg::*;

  localparam int RUN_LIMIT    = 2_000_000;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 64;

  // Codes with no name in the package
  localparam logic [2:0]           KIND_SPARE   = 3'd7;
  localparam logic [1:0]           CODE_VRAM_WR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam logic [7:0]           FRAME_FLAG   = 8'h80;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Request backlog and replies still owed by the block
  in_item_t  cpu_requests[$];
  out_item_t owed_replies[$];
  int        queued_total = 0;
  int        in_gap_max   = 0;
  int        rx_gap_max   = 0;
  int        send_gap     = 0;
  int        rx_wait      = 0;
  int        rx_done      = 0;
  int        faults       = 0;
  out_item_t want;

  // Shadow copy of the port, memories and scanline timing
  logic [7:0]  vram_img [VRAM_DEPTH_DEF];
  logic [7:0]  cram_img [32];
  logic [7:0]  mode_reg [16];
  logic [13:0] acc_addr;
  logic [1:0]  acc_code;
  logic [7:0]  first_byte;
  logic        second_due;
  logic [7:0]  prefetch;
  logic [7:0]  status_reg;
  int          cycle_pos;
  int          cur_line;
  logic [7:0]  line_cnt;
  logic        frame_top;
  logic        line_flag;
  int          line_len;
  int          frame_len;

  always #2 clk = ~clk;

  video_chip_port_and_line_timing_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic void shadow_reset();
    foreach (vram_img[i]) vram_img[i] = '0;
    foreach (cram_img[i]) cram_img[i] = '0;
    foreach (mode_reg[i]) mode_reg[i] = '0;
    acc_addr   = '0;
    acc_code   = '0;
    first_byte = '0;
    second_due = 1'b0;
    prefetch   = '0;
    status_reg = '0;
    cycle_pos  = 0;
    cur_line   = 0;
    line_cnt   = '0;
    frame_top  = 1'b1;
    line_flag  = 1'b0;
    line_len   = CPL_DEF;
    frame_len  = LPF_DEF;
  endfunction

  // Pull the position back inside a shortened line or frame
  function automatic void fit_position();
    if (cur_line >= frame_len) begin
      cur_line  = 0;
      frame_top = 1'b1;
    end
    if (cycle_pos >= line_len) cycle_pos = cycle_pos % line_len;
  endfunction

  function automatic void timing_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_CPL) begin
      line_len = (val == 0) ? CPL_DEF : int'(val);
      fit_position();
    end else if (idx == CFG_LPF) begin
      frame_len = (int'(val[8:0]) > ACTIVE_LINES) ? int'(val[8:0]) : LPF_DEF;
      fit_position();
    end
  endfunction

  // One scanline boundary: line counter, frame flag and wrap
  function automatic void cross_line();
    if (cur_line < ACTIVE_LINES) begin
      if (frame_top) begin
        line_cnt  = mode_reg[MREG_10];
        frame_top = 1'b0;
      end else if (line_cnt == 0) begin
        line_cnt  = mode_reg[MREG_10];
        line_flag = 1'b1;
      end else begin
        line_cnt = line_cnt - 8'd1;
      end
    end
    cur_line++;
    if (cur_line == ACTIVE_LINES) begin
      status_reg = status_reg | FRAME_FLAG;
      line_cnt   = mode_reg[MREG_10];
    end
    if (cur_line >= frame_len) begin
      cur_line  = 0;
      frame_top = 1'b1;
    end
  endfunction

  function automatic void control_byte(logic [7:0] v);
    if (!second_due) begin
      first_byte = v;
      second_due = 1'b1;
    end else begin
      acc_code = v[7:6];
      acc_addr = {v[5:0], first_byte};
      if (acc_code == CODE_VRAM_RD) begin
        prefetch = vram_img[acc_addr];
        acc_addr = acc_addr + 14'd1;
      end
      if (acc_code == CODE_REG_WR) begin
        mode_reg[v[3:0]] = first_byte;
        if (v[3:0] == MREG_10) line_cnt = first_byte;
      end
      second_due = 1'b0;
    end
  endfunction

  // Apply one request to the shadow state and return the reply it owes
  function automatic out_item_t port_reply(in_item_t req);
    out_item_t  r;
    logic [7:0] rv;
    int         vl;
    int         hq;
    rv = '0;
    case (req.kind)
      KIND_CTRL_WR: control_byte(req.data_byte);
      KIND_DATA_WR: begin
        second_due = 1'b0;
        if (acc_code == CODE_CRAM_WR) cram_img[acc_addr[4:0]] = req.data_byte;
        else vram_img[acc_addr] = req.data_byte;
        acc_addr = acc_addr + 14'd1;
      end
      KIND_DATA_RD: begin
        rv         = prefetch;
        prefetch   = vram_img[acc_addr];
        acc_addr   = acc_addr + 14'd1;
        second_due = 1'b0;
      end
      KIND_STAT_RD: begin
        rv         = status_reg;
        status_reg = '0;
        line_flag  = 1'b0;
        second_due = 1'b0;
      end
      KIND_VCOUNT: begin
        if (frame_len >= LPF_PAL_MIN)
          vl = (cur_line <= VC_PAL_LIM) ? cur_line : cur_line - VC_PAL_SKIP;
        else
          vl = (cur_line <= VC_NTSC_LIM) ? cur_line : cur_line - VC_NTSC_SKIP;
        rv = vl[7:0];
      end
      KIND_HCOUNT: begin
        hq = (cycle_pos * HC_SCALE) / line_len;
        rv = hq[7:0];
      end
      KIND_TICK: begin
        cycle_pos += int'(req.tick_cycles);
        while (cycle_pos >= line_len) begin
          cycle_pos -= line_len;
          cross_line();
        end
      end
      default: ;
    endcase
    r.read_value = rv;
    r.irq = (status_reg[7] && mode_reg[MREG_1][5]) || (line_flag && mode_reg[MREG_0][4]);
    return r;
  endfunction

  // Request driver: hold until accepted, then wait the drawn gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        owed_replies = {owed_replies, port_reply(in_data)};
        send_gap = $urandom_range(0, in_gap_max);
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cpu_requests.size() != 0) begin
          in_data  <= cpu_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor: check in order, stall at random, hold off now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          $error("reply with none owed: read_value %0h irq %0b", out_data.read_value,
                 out_data.irq);
          faults++;
        end else begin
          want = owed_replies.pop_front();
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %0h, got %0h", want.read_value, out_data.read_value);
            faults++;
          end
          if (out_data.irq !== want.irq) begin
            $error("irq: expected %0b, got %0b", want.irq, out_data.irq);
            faults++;
          end
        end
        rx_done++;
        if (rx_done % 400 == 150) rx_wait = LONG_HOLD;
        else rx_wait = $urandom_range(0, rx_gap_max);
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_req(logic [2:0] kind, logic [7:0] data_byte, logic [7:0] cycles);
    in_item_t r;
    r.kind        = kind;
    r.data_byte   = data_byte;
    r.tick_cycles = cycles;
    cpu_requests = {cpu_requests, r};
    queued_total++;
  endtask

  // Two control bytes selecting an access code and address
  task automatic set_access(logic [1:0] code, logic [13:0] addr);
    add_req(KIND_CTRL_WR, addr[7:0], 8'($urandom));
    add_req(KIND_CTRL_WR, {code, addr[13:8]}, 8'($urandom));
  endtask

  // Half the time a small window so reads hit earlier writes; else the top or anywhere
  function automatic logic [13:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return 14'($urandom);
      1:       return 14'h3FFC + 14'($urandom_range(0, 3));
      default: return 14'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic queue_random(int count);
    int          goal;
    int          pick;
    int          n;
    logic [3:0]  reg_sel;
    logic [7:0]  val;
    goal = queued_total + count;
    while (queued_total < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        add_req(KIND_TICK, 8'($urandom), 8'($urandom));
      end else if (pick < 40) begin
        set_access(CODE_VRAM_WR, pick_addr());
        n = $urandom_range(1, 4);
        repeat (n) add_req(KIND_DATA_WR, 8'($urandom), 8'($urandom));
      end else if (pick < 50) begin
        set_access(CODE_VRAM_RD, pick_addr());
        n = $urandom_range(1, 4);
        repeat (n) add_req(KIND_DATA_RD, 8'($urandom), 8'($urandom));
      end else if (pick < 56) begin
        set_access(CODE_CRAM_WR, pick_addr());
        n = $urandom_range(1, 3);
        repeat (n) add_req(KIND_DATA_WR, 8'($urandom), 8'($urandom));
      end else if (pick < 64) begin
        case ($urandom_range(0, 3))
          0:       reg_sel = MREG_0;
          1:       reg_sel = MREG_1;
          2:       reg_sel = MREG_10;
          default: reg_sel = 4'($urandom);
        endcase
        val = (reg_sel == MREG_10 && $urandom_range(0, 1)) ? 8'($urandom_range(0, 15))
                                                           : 8'($urandom);
        add_req(KIND_CTRL_WR, val, 8'($urandom));
        add_req(KIND_CTRL_WR, {CODE_REG_WR, 2'($urandom), reg_sel}, 8'($urandom));
      end else if (pick < 72) begin
        add_req(KIND_STAT_RD, 8'($urandom), 8'($urandom));
      end else if (pick < 80) begin
        add_req($urandom_range(0, 1) ? KIND_VCOUNT : KIND_HCOUNT, 8'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        add_req(3'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        // Lone first byte dropped by a read or write
        add_req(KIND_CTRL_WR, 8'($urandom), 8'($urandom));
        case ($urandom_range(0, 2))
          0:       add_req(KIND_DATA_WR, 8'($urandom), 8'($urandom));
          1:       add_req(KIND_DATA_RD, 8'($urandom), 8'($urandom));
          default: add_req(KIND_STAT_RD, 8'($urandom), 8'($urandom));
        endcase
      end
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timing_write(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request has gone in and every reply has come back
  task automatic settle();
    do @(posedge clk);
    while (cpu_requests.size() != 0 || in_valid || owed_replies.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int in_max, int rx_max, int count);
    in_gap_max = in_max;
    rx_gap_max = rx_max;
    queue_random(count);
    settle();
  endtask

  // Run watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    shadow_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: counters at reset, VRAM write and prefetch, irq enables, colour RAM
    // at the top address, tick extremes, spare kind and a dropped first byte
    in_gap_max = 1;
    rx_gap_max = 1;
    add_req(KIND_VCOUNT, 8'h00, 8'h00);
    add_req(KIND_HCOUNT, 8'hFF, 8'hFF);
    set_access(CODE_VRAM_WR, 14'h0000);
    add_req(KIND_DATA_WR, 8'hFF, 8'h00);
    add_req(KIND_DATA_WR, 8'h00, 8'hFF);
    set_access(CODE_VRAM_RD, 14'h0000);
    add_req(KIND_DATA_RD, 8'h00, 8'h00);
    add_req(KIND_DATA_RD, 8'h00, 8'h00);
    add_req(KIND_CTRL_WR, 8'h20, 8'h00);
    add_req(KIND_CTRL_WR, {CODE_REG_WR, 2'b00, MREG_1}, 8'h00);
    add_req(KIND_CTRL_WR, 8'h10, 8'h00);
    add_req(KIND_CTRL_WR, {CODE_REG_WR, 2'b00, MREG_0}, 8'h00);
    add_req(KIND_CTRL_WR, 8'h00, 8'h00);
    add_req(KIND_CTRL_WR, {CODE_REG_WR, 2'b00, MREG_10}, 8'h00);
    set_access(CODE_CRAM_WR, 14'h3FFF);
    add_req(KIND_DATA_WR, 8'hA5, 8'h00);
    add_req(KIND_TICK, 8'h00, 8'hFF);
    add_req(KIND_TICK, 8'hFF, 8'h00);
    add_req(KIND_SPARE, 8'hFF, 8'hFF);
    add_req(KIND_CTRL_WR, 8'h12, 8'h00);
    add_req(KIND_STAT_RD, 8'h00, 8'h00);
    set_access(CODE_VRAM_RD, 14'h3FFF);
    add_req(KIND_DATA_RD, 8'h00, 8'h00);
    settle();

    // Shortest line, longest frame (top data bit ignored); no idling
    cfg_write(CFG_CPL, 10'd1);
    cfg_write(CFG_LPF, 10'h3FF);
    run_phase(0, 0, 250);

    // Shortest frame cuts the current line back; longest line
    cfg_write(CFG_LPF, 10'(ACTIVE_LINES + 1));
    cfg_write(CFG_CPL, 10'h3FF);
    run_phase(3, 3, 200);

    // Zero line length and too few lines fall back to defaults; unmapped index ignored
    cfg_write(CFG_CPL, 10'd0);
    cfg_write(CFG_LPF, 10'(ACTIVE_LINES));
    cfg_write(CFG_SPARE, 10'h3FF);
    cfg_write(CFG_LPF, 10'd0);
    cfg_write(CFG_CPL, 10'd3);
    run_phase(0, 3, 250);

    // 50 Hz counter map with short lines
    cfg_write(CFG_CPL, 10'($urandom_range(20, 80)));
    cfg_write(CFG_LPF, 10'd313);
    run_phase(3, 0, 250);

    // Anything in range
    cfg_write(CFG_CPL, 10'($urandom_range(1, 1023)));
    cfg_write(CFG_LPF, 10'($urandom_range(ACTIVE_LINES + 1, 511)));
    run_phase(2, 2, 250);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_replies.size() != 0) begin
      $error("%0d replies never arrived", owed_replies.size());
      faults++;
    end
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
